>>> src/lspd_pkg.sv
// shared constants and control/status types for the lidar scan packet deframer
package lspd_pkg;

   localparam int          HEADER_BYTES_DEFAULT = 8;
   localparam int          HEADER_USED          = 6;
   localparam int          DIV_STEPS            = 31;

   localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND  = 8'h55;
   localparam logic [7:0]  LIMIT_RESET  = 8'd10;
   localparam logic [7:0]  FREQ_OFFSET  = 8'd30;
   localparam logic [15:0] FULL_TURN    = 16'd23040;

   localparam logic [1:0]  KIND_SAMPLE    = 2'd0;
   localparam logic [1:0]  KIND_START     = 2'd1;
   localparam logic [1:0]  KIND_SYNC_FAIL = 2'd2;

   typedef struct packed {
      logic hunt_byte;
      logic header_byte;
      logic low_byte;
      logic high_byte;
      logic div_load;
      logic emit_fail;
      logic emit_start;
      logic emit_sample;
   } cmd_type;

   typedef struct packed {
      logic sync_hit;
      logic hunt_fail;
      logic header_last;
      logic div_done;
      logic count_zero;
      logic start_flag;
      logic last_sample;
      logic dist_nonzero;
      logic out_free;
   } status_type;

endpackage

>>> src/lspd_ctrl.sv
// packet phase state machine: sequences hunt, header, step divide and distance beats
module lspd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lspd_pkg::status_type status,
   output lspd_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_HUNT   = 3'd0;
   localparam logic [2:0] ST_HEADER = 3'd1;
   localparam logic [2:0] ST_SETUP  = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_LOW    = 3'd4;
   localparam logic [2:0] ST_HIGH   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_HUNT: begin
            req_tready = status.out_free;
            if (req_tvalid && req_tready) begin
               cmd.hunt_byte = 1'b1;
               if (status.sync_hit) begin
                  state_in = ST_HEADER;
               end else if (status.hunt_fail) begin
                  cmd.emit_fail = 1'b1;
               end
            end
         end
         ST_HEADER: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tready) begin
               cmd.header_byte = 1'b1;
               if (status.header_last) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // scan start beat needs the output register only when flagged
            if (status.div_done && (status.out_free || !status.start_flag)) begin
               cmd.emit_start = status.start_flag;
               state_in       = status.count_zero ? ST_HUNT : ST_LOW;
            end
         end
         ST_LOW: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tready) begin
               cmd.low_byte = 1'b1;
               state_in     = ST_HIGH;
            end
         end
         ST_HIGH: begin
            req_tready = status.out_free;
            if (req_tvalid && req_tready) begin
               cmd.high_byte   = 1'b1;
               cmd.emit_sample = status.dist_nonzero;
               state_in        = status.last_sample ? ST_HUNT : ST_LOW;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_fail, cmd.emit_start, cmd.emit_sample}))
      else $error("more than one result source in a cycle");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_fail || cmd.emit_start || cmd.emit_sample) |-> status.out_free)
      else $error("result loaded while output register occupied");

   a_no_take_in_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP || state_ff == ST_DIVIDE) |-> !req_tready)
      else $error("byte taken while the angle step is being worked out");

   a_setup_to_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |=> (state_ff == ST_DIVIDE))
      else $error("setup not followed by divide");

endmodule

>>> src/lspd_datapath.sv
// deframer datapath: hunt counter, header store, serial step divider, angle accumulator, output register
module lspd_datapath #(
   parameter int HEADER_BYTES = lspd_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [7:0]           csr_wdata,
   input  logic [7:0]           rx_byte,
   input  lspd_pkg::cmd_type    cmd,
   output lspd_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_kind,
   output logic [39:0]          rsp_data
);

   localparam int               POS_W    = $clog2(HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);
   localparam logic [POS_W-1:0] POS_USED = POS_W'(lspd_pkg::HEADER_USED);

   // control state
   logic [7:0]       limit_ff,    limit_in;
   logic [7:0]       prev_ff,     prev_in;
   logic [7:0]       hunt_cnt_ff, hunt_cnt_in;
   logic [POS_W-1:0] pos_ff,      pos_in;
   logic             div_busy_ff, div_busy_in;
   logic [4:0]       div_cnt_ff,  div_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [7:0]  store_ff [lspd_pkg::HEADER_USED];
   logic [7:0]  store_in [lspd_pkg::HEADER_USED];
   logic [31:0] step_ff,    step_in;
   logic [39:0] acc_ff,     acc_in;
   logic [7:0]  smp_pos_ff, smp_pos_in;
   logic [7:0]  low_ff,     low_in;
   logic [7:0]  div_rem_ff, div_rem_in;
   logic [30:0] div_quo_ff, div_quo_in;
   logic [7:0]  div_den_ff, div_den_in;
   logic        div_neg_ff, div_neg_in;
   logic        div_null_ff, div_null_in;
   logic [1:0]  kind_ff,    kind_in;
   logic [39:0] data_ff,    data_in;

   // combinational helpers
   logic [7:0]  hunt_next;
   logic [7:0]  smp_next;
   logic [14:0] first_angle;
   logic [14:0] last_angle;
   logic [16:0] span;
   logic [16:0] span_abs;
   logic [8:0]  div_shift;
   logic        div_fits;
   logic [8:0]  div_diff;
   logic [7:0]  div_rem_next;
   logic [30:0] div_quo_next;
   logic [31:0] q_mag;
   logic [23:0] ipart;
   logic [23:0] angle_wrapped;
   logic [15:0] distance;

   assign hunt_next = hunt_cnt_ff + 8'd1;
   assign smp_next  = smp_pos_ff + 8'd1;
   assign distance  = {rx_byte, low_ff};

   assign status.sync_hit     = (prev_ff == lspd_pkg::SYNC_FIRST)
                                && (rx_byte == lspd_pkg::SYNC_SECOND);
   assign status.hunt_fail    = hunt_next >= limit_ff;
   assign status.header_last  = pos_ff == POS_LAST;
   assign status.div_done     = !div_busy_ff;
   assign status.count_zero   = store_ff[1] == 8'd0;
   assign status.start_flag   = store_ff[0][0];
   assign status.last_sample  = smp_next >= store_ff[1];
   assign status.dist_nonzero = distance != 16'd0;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   // header angles are the 16-bit word shifted right by one
   assign first_angle = {store_ff[3], store_ff[2][7:1]};
   assign last_angle  = {store_ff[5], store_ff[4][7:1]};

   always_comb begin
      span = {2'b00, last_angle} - {2'b00, first_angle};
      if (last_angle < first_angle) begin
         span = span + {1'b0, lspd_pkg::FULL_TURN};
      end
      span_abs = span[16] ? (17'd0 - span) : span;
   end

   // one restoring quotient bit per cycle
   assign div_shift    = {div_rem_ff, div_quo_ff[30]};
   assign div_fits     = div_shift >= {1'b0, div_den_ff};
   assign div_diff     = div_shift - {1'b0, div_den_ff};
   assign div_rem_next = div_fits ? div_diff[7:0] : div_shift[7:0];
   assign div_quo_next = {div_quo_ff[29:0], div_fits};
   // negative span floors toward minus infinity
   assign q_mag = {1'b0, div_quo_next}
                  + {31'd0, div_neg_ff && (div_rem_next != 8'd0)};

   assign ipart = acc_ff[39:16];
   always_comb begin
      angle_wrapped = ipart;
      if (!ipart[23] && (ipart >= {8'd0, lspd_pkg::FULL_TURN})) begin
         angle_wrapped = ipart - {8'd0, lspd_pkg::FULL_TURN};
      end
   end

   always_comb begin
      limit_in     = csr_wen ? csr_wdata : limit_ff;
      prev_in      = prev_ff;
      hunt_cnt_in  = hunt_cnt_ff;
      pos_in       = pos_ff;
      store_in     = store_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      smp_pos_in   = smp_pos_ff;
      low_in       = low_ff;
      div_busy_in  = div_busy_ff;
      div_cnt_in   = div_cnt_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      div_neg_in   = div_neg_ff;
      div_null_in  = div_null_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      data_in      = data_ff;

      if (cmd.hunt_byte) begin
         prev_in = rx_byte;
         if (status.sync_hit) begin
            hunt_cnt_in = 8'd0;
            pos_in      = '0;
         end else if (status.hunt_fail) begin
            hunt_cnt_in = 8'd0;
         end else begin
            hunt_cnt_in = hunt_next;
         end
      end

      if (cmd.header_byte) begin
         if (pos_ff < POS_USED) begin
            store_in[pos_ff[2:0]] = rx_byte;
         end
         pos_in = status.header_last ? '0 : pos_ff + POS_W'(1);
      end

      if (cmd.div_load) begin
         div_busy_in = 1'b1;
         div_cnt_in  = 5'(lspd_pkg::DIV_STEPS);
         div_rem_in  = 8'd0;
         div_quo_in  = {span_abs[14:0], 16'd0};
         div_den_in  = store_ff[1] - 8'd1;
         div_neg_in  = span[16];
         div_null_in = store_ff[1] < 8'd2;
         acc_in      = {9'd0, first_angle, 16'd0};
         smp_pos_in  = 8'd0;
      end else if (div_busy_ff) begin
         div_rem_in = div_rem_next;
         div_quo_in = div_quo_next;
         div_cnt_in = div_cnt_ff - 5'd1;
         if (div_cnt_ff == 5'd1) begin
            div_busy_in = 1'b0;
            if (div_null_ff) begin
               step_in = 32'd0;
            end else if (div_neg_ff) begin
               step_in = 32'd0 - q_mag;
            end else begin
               step_in = q_mag;
            end
         end
      end

      if (cmd.low_byte) begin
         low_in = rx_byte;
      end

      if (cmd.high_byte) begin
         acc_in     = acc_ff + {{8{step_ff[31]}}, step_ff};
         smp_pos_in = smp_next;
      end

      if (cmd.emit_fail) begin
         rsp_valid_in = 1'b1;
         kind_in      = lspd_pkg::KIND_SYNC_FAIL;
         data_in      = 40'd0;
      end else if (cmd.emit_start) begin
         rsp_valid_in = 1'b1;
         kind_in      = lspd_pkg::KIND_START;
         data_in      = {({1'b0, store_ff[0][7:1]} + lspd_pkg::FREQ_OFFSET), 32'd0};
      end else if (cmd.emit_sample) begin
         rsp_valid_in = 1'b1;
         kind_in      = lspd_pkg::KIND_SAMPLE;
         data_in      = {8'd0, angle_wrapped[15:0], distance};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= lspd_pkg::LIMIT_RESET;
         prev_ff      <= 8'd0;
         hunt_cnt_ff  <= 8'd0;
         pos_ff       <= '0;
         div_busy_ff  <= 1'b0;
         div_cnt_ff   <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         prev_ff      <= prev_in;
         hunt_cnt_ff  <= hunt_cnt_in;
         pos_ff       <= pos_in;
         div_busy_ff  <= div_busy_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff    <= store_in;
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      smp_pos_ff  <= smp_pos_in;
      low_ff      <= low_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      div_neg_ff  <= div_neg_in;
      div_null_ff <= div_null_in;
      kind_ff     <= kind_in;
      data_ff     <= data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_data  = data_ff;

   a_load_starts_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> (div_busy_ff && div_cnt_ff == 5'(lspd_pkg::DIV_STEPS)))
      else $error("divider not started by load");

   a_no_sample_mid_div: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !(cmd.high_byte || cmd.emit_start))
      else $error("step used before the divider finished");

endmodule

>>> src/lidar_scan_packet_deframer.sv
// top level of the lidar scan packet deframer: controller plus datapath
//
//   group   direction  payload                                      note
//   req_    in         tdata[7:0] rx_byte                           one link byte per beat
//   rsp_    out        tdata distance/angle/freq, tuser kind        at most one per byte
//   csr_    in         wdata[7:0] sync_attempt_limit                write only, reset 10
//
// hunt, header and distance bytes are taken one per beat; after the last header byte
// the angle step comes from a serial restoring divider, one quotient bit per cycle,
// so that header ends with a setup step, 31 quotient bits and a hand-off, all without input.
// a byte that may give a result is taken only when the output register is free or
// being emptied in the same cycle; other bytes never wait on the output side.
// reset is synchronous and returns the block to hunting with the limit at 10.
module lidar_scan_packet_deframer #(
   parameter int HEADER_BYTES = lspd_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] distance, [31:16] angle, [39:32] scan_freq_tenths
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata    // [7:0] sync_attempt_limit
);

   lspd_pkg::cmd_type    cmd;
   lspd_pkg::status_type status;

   lspd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lspd_datapath #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .rx_byte   (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_kind  (rsp_tuser),
      .rsp_data  (rsp_tdata)
   );

endmodule
